// ===== sv/assert_macros.svh =====
// assertion helpers for the rtl file command_line_tokenizer.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cltok_pkg.sv =====
// ----------------------------------------------------------------------------
// cltok_pkg
// Types and constants of the command line tokenizer.
// ----------------------------------------------------------------------------
package cltok_pkg;

  localparam int MAX_LINE_BYTES = 8192;
  localparam int MAX_TOKENS     = 1024;
  localparam int POS_W          = $clog2(MAX_LINE_BYTES);
  localparam int TOK_W          = $clog2(MAX_TOKENS + 1);
  localparam int RES_MAX        = 3;
  localparam int RES_N_W        = $clog2(RES_MAX + 1);

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_IGNORE_QUOTES = 3'h0;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_COLON = 8'h3a;
  localparam logic [7:0] CHR_LA    = 8'h61;
  localparam logic [7:0] CHR_LZ    = 8'h7a;
  localparam logic [7:0] CHR_SLASH = 8'h2f;
  localparam logic [7:0] CHR_STAR  = 8'h2a;
  localparam logic [7:0] CHR_QUOTE = 8'h22;

  typedef enum logic [4:0] {
    MODE_SKIP   = 5'b00001,
    MODE_REG    = 5'b00010,
    MODE_QUOTE  = 5'b00100,
    MODE_CMT    = 5'b01000,
    MODE_CMTEND = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [9:0]  token_index;
    logic        token_end;
    logic        line_done;
    logic [10:0] token_count;
  } res_t;

  typedef struct packed {
    mode_e            mode;
    logic [7:0]       held_byte;
    logic             held_valid;
    logic [7:0]       before_one;
    logic [7:0]       before_two;
    logic [POS_W-1:0] pos;
    logic [TOK_W-1:0] tokens;
    logic             fin;
  } st_t;

  typedef struct packed {
    res_t [RES_MAX-1:0] slot;
    logic [RES_N_W-1:0] n;
  } rlist_t;

  typedef struct packed {
    st_t    st;
    rlist_t rl;
    logic   closed;
  } ctx_t;

endpackage

// ===== sv/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Results appear in the cycle after the input transaction; one byte per cycle when not stalled.
// A byte that yields k results (k up to 3) holds off input until only one is
// left and not stalled; the result register drains one per cycle when not stalled.
// Reset clears parse state, result count and ignore_quotes; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module command_line_tokenizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cltok_pkg::in_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cltok_pkg::res_t                 out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cltok_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic                                iq_q;
  cltok_pkg::st_t                      st_q;
  cltok_pkg::ctx_t                     ctx_d;
  cltok_pkg::res_t [cltok_pkg::RES_MAX-1:0] slot_q;
  logic [cltok_pkg::RES_N_W-1:0]       cnt_q;
  logic                                in_acc;
  logic                                out_acc;

  function automatic logic is_space(logic [7:0] b);
    return ((b != cltok_pkg::CHR_NUL) && (b <= cltok_pkg::CHR_SPACE)) || b[7];
  endfunction

  function automatic logic [9:0] cur_index(cltok_pkg::st_t s);
    logic [cltok_pkg::TOK_W-1:0] idx;
    idx = (s.tokens != '0) ? s.tokens - cltok_pkg::TOK_W'(1) : '0;
    return 10'(idx);
  endfunction

  function automatic cltok_pkg::ctx_t push(cltok_pkg::ctx_t c, logic [7:0] b,
                                           logic bv, logic [9:0] idx, logic te,
                                           logic ld);
    cltok_pkg::res_t r;
    r.out_byte    = b;
    r.byte_valid  = bv;
    r.token_index = idx;
    r.token_end   = te;
    r.line_done   = ld;
    r.token_count = 11'(c.st.tokens);
    if (c.rl.n < cltok_pkg::RES_N_W'(cltok_pkg::RES_MAX)) begin
      c.rl.slot[c.rl.n] = r;
      c.rl.n            = c.rl.n + cltok_pkg::RES_N_W'(1);
    end
    return c;
  endfunction

  function automatic cltok_pkg::ctx_t close_token(cltok_pkg::ctx_t c);
    c = push(c, cltok_pkg::CHR_NUL, 1'b0, cur_index(c.st), 1'b1, 1'b0);
    c.st.mode = cltok_pkg::MODE_SKIP;
    if (c.st.tokens >= cltok_pkg::TOK_W'(cltok_pkg::MAX_TOKENS)) begin
      c.st.fin = 1'b1;
    end
    return c;
  endfunction

  // decide byte h with lookahead la
  function automatic cltok_pkg::ctx_t decide(cltok_pkg::ctx_t c, logic [7:0] h,
                                             logic [7:0] la, logic iq);
    logic proto;
    logic quote;
    logic lcmt;
    logic bcmt;
    logic sp;
    logic go_skip;
    proto = (c.st.pos >= cltok_pkg::POS_W'(4)) &&
            (c.st.before_one == cltok_pkg::CHR_COLON) &&
            (c.st.before_two >= cltok_pkg::CHR_LA) &&
            (c.st.before_two <= cltok_pkg::CHR_LZ);
    quote   = (h == cltok_pkg::CHR_QUOTE) && !iq;
    lcmt    = (h == cltok_pkg::CHR_SLASH) && (la == cltok_pkg::CHR_SLASH) && !proto;
    bcmt    = (h == cltok_pkg::CHR_SLASH) && (la == cltok_pkg::CHR_STAR);
    sp      = is_space(h);
    go_skip = 1'b0;
    if (!c.st.fin) begin
      if (c.st.mode == cltok_pkg::MODE_QUOTE) begin
        if (h == cltok_pkg::CHR_QUOTE) begin
          c = close_token(c);
        end else begin
          c = push(c, h, 1'b1, cur_index(c.st), 1'b0, 1'b0);
        end
      end else if (c.st.mode == cltok_pkg::MODE_CMT) begin
        if ((h == cltok_pkg::CHR_STAR) && (la == cltok_pkg::CHR_SLASH)) begin
          c.st.mode = cltok_pkg::MODE_CMTEND;
        end
      end else if (c.st.mode == cltok_pkg::MODE_CMTEND) begin
        c.st.mode = cltok_pkg::MODE_SKIP;
      end else begin
        go_skip = 1'b1;
        if (c.st.mode == cltok_pkg::MODE_REG) begin
          if (!(sp || quote || lcmt || bcmt)) begin
            c       = push(c, h, 1'b1, cur_index(c.st), 1'b0, 1'b0);
            go_skip = 1'b0;
          end else begin
            c = close_token(c);
            if (c.st.fin) begin
              go_skip = 1'b0;
            end
          end
        end
      end
      if (go_skip) begin
        c.st.mode = cltok_pkg::MODE_SKIP;
        if (!(sp || (h == cltok_pkg::CHR_NUL))) begin
          if (lcmt) begin
            c.st.fin = 1'b1;
          end else if (bcmt) begin
            c.st.mode = cltok_pkg::MODE_CMT;
          end else if (c.st.tokens >= cltok_pkg::TOK_W'(cltok_pkg::MAX_TOKENS)) begin
            c.st.fin = 1'b1;
          end else begin
            c.st.tokens = c.st.tokens + cltok_pkg::TOK_W'(1);
            if (quote) begin
              c.st.mode = cltok_pkg::MODE_QUOTE;
            end else begin
              c.st.mode = cltok_pkg::MODE_REG;
              c = push(c, h, 1'b1, cur_index(c.st), 1'b0, 1'b0);
            end
          end
        end
      end
    end
    return c;
  endfunction

  // end of kept text: flush held byte, close open token
  function automatic cltok_pkg::ctx_t end_text(cltok_pkg::ctx_t c, logic iq);
    if (c.st.held_valid) begin
      c = decide(c, c.st.held_byte, cltok_pkg::CHR_NUL, iq);
    end
    c.st.held_valid = 1'b0;
    if (!c.st.fin && ((c.st.mode == cltok_pkg::MODE_REG) ||
                      (c.st.mode == cltok_pkg::MODE_QUOTE))) begin
      c        = push(c, cltok_pkg::CHR_NUL, 1'b0, cur_index(c.st), 1'b1, 1'b0);
      c.closed = 1'b1;
    end
    c.st.mode = cltok_pkg::MODE_SKIP;
    c.st.fin  = 1'b1;
    return c;
  endfunction

  function automatic cltok_pkg::ctx_t finish_line(cltok_pkg::ctx_t c);
    if (c.closed && (c.rl.n != '0)) begin
      c.rl.slot[c.rl.n - cltok_pkg::RES_N_W'(1)].line_done = 1'b1;
    end else begin
      c = push(c, cltok_pkg::CHR_NUL, 1'b0, 10'd0, 1'b0, 1'b1);
    end
    c.st.mode       = cltok_pkg::MODE_SKIP;
    c.st.held_byte  = '0;
    c.st.held_valid = 1'b0;
    c.st.before_one = '0;
    c.st.before_two = '0;
    c.st.pos        = '0;
    c.st.tokens     = '0;
    c.st.fin        = 1'b0;
    return c;
  endfunction

  // one input transaction
  always_comb begin
    ctx_d        = '0;
    ctx_d.st     = st_q;
    if (st_q.fin) begin
      if ((in_data_i.char_byte == cltok_pkg::CHR_NUL) || in_data_i.last_byte) begin
        ctx_d = finish_line(ctx_d);
      end
    end else if (in_data_i.char_byte == cltok_pkg::CHR_NUL) begin
      ctx_d = finish_line(end_text(ctx_d, iq_q));
    end else if (st_q.pos >= cltok_pkg::POS_W'(cltok_pkg::MAX_LINE_BYTES - 1)) begin
      ctx_d = end_text(ctx_d, iq_q);
      if (in_data_i.last_byte) begin
        ctx_d = finish_line(ctx_d);
      end
    end else begin
      if (st_q.held_valid) begin
        ctx_d               = decide(ctx_d, st_q.held_byte, in_data_i.char_byte, iq_q);
        ctx_d.st.before_two = st_q.before_one;
        ctx_d.st.before_one = st_q.held_byte;
      end
      ctx_d.st.held_byte  = in_data_i.char_byte;
      ctx_d.st.held_valid = 1'b1;
      ctx_d.st.pos        = st_q.pos + cltok_pkg::POS_W'(1);
      if (in_data_i.last_byte) begin
        ctx_d = finish_line(end_text(ctx_d, iq_q));
      end
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = slot_q[0];
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = (cnt_q > cltok_pkg::RES_N_W'(1)) ||
                       ((cnt_q == cltok_pkg::RES_N_W'(1)) && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '{mode: cltok_pkg::MODE_SKIP, default: '0};
      cnt_q      <= '0;
    end else if (in_acc) begin
      st_q  <= ctx_d.st;
      cnt_q <= ctx_d.rl.n;
    end else if (out_acc) begin
      cnt_q <= cnt_q - cltok_pkg::RES_N_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q <= ctx_d.rl.slot;
    end else if (out_acc) begin
      for (int i = 0; i < cltok_pkg::RES_MAX - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr)
      cltok_pkg::ADDR_IGNORE_QUOTES: prdata = {31'd0, iq_q};
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iq_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == cltok_pkg::ADDR_IGNORE_QUOTES)) begin
      iq_q <= pwdata[0];
    end
  end

  `ASSERT_IMPLIES(a_fin_skip, clk_i, rst_ni, st_q.fin, st_q.mode == cltok_pkg::MODE_SKIP, "finished line left parse mode active")
  `ASSERT_IMPLIES(a_done_last, clk_i, rst_ni, out_acc && out_data_o.line_done, cnt_q == cltok_pkg::RES_N_W'(1), "line_done transaction not last of its batch")
  `ASSERT_IMPLIES(a_byte_end, clk_i, rst_ni, out_valid_o, !(out_data_o.byte_valid && out_data_o.token_end), "token end carries a byte")
  `ASSERT_NEXT(a_nul_clear, clk_i, rst_ni, in_acc && (in_data_i.char_byte == cltok_pkg::CHR_NUL), (st_q.pos == '0) && (st_q.tokens == '0), "terminator did not clear line state")

endmodule
